// File: sv/crd_pkg.sv
package crd_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int KEY_BYTES         = 4;
    localparam int KEY_BITS          = 8 * KEY_BYTES;
    localparam int MAX_DIGITS        = (2 * KEY_BYTES < 8) ? 2 * KEY_BYTES : 8;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_STORE  = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    localparam logic [1:0] KIND_ADMIN = 2'd0;
    localparam logic [1:0] KIND_USER  = 2'd1;
    localparam logic [1:0] KIND_ANY   = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [1:0]          kind;
    } entry_t;

    function automatic logic [KEY_BITS-1:0] pack_key(input logic [31:0] digits,
                                                    input logic [3:0]  count);
        logic [KEY_BITS-1:0] key;
        logic [3:0]          n;
        key = '1;
        n   = (count > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : count;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (4'(i) < n) begin
                key[KEY_BITS-4-4*i +: 4] = digits[28-4*i +: 4];
            end
        end
        return key;
    endfunction

endpackage

// File: sv/crd_cell.sv
module crd_cell
    import crd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   shift_en,
    input  entry_t entry_in,
    output entry_t entry_out
);

    logic                valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [1:0]          kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= entry_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg  <= entry_in.key;
            kind_reg <= entry_in.kind;
        end
    end

    assign entry_out = '{valid: valid_reg, key: key_reg, kind: kind_reg};

endmodule

// File: sv/crd_ctrl.sv
module crd_ctrl
    import crd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_digits,
    input  logic [3:0]  s_digit_count,
    input  logic [1:0]  s_code_type,
    input  logic [6:0]  s_entry_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [6:0]  m_slot,
    output logic        m_free_found,
    output logic [6:0]  m_free_slot,
    input  entry_t      head_entry,
    output entry_t      wb_entry,
    output logic        shift_en
);

    localparam int IW = $clog2(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_APPLY,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [IW-1:0]       pos_reg, pos_next;
    op_t                 op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [1:0]          type_reg, type_next;
    logic [6:0]          idx_reg, idx_next;
    logic                match_found_reg, match_found_next;
    logic [IW-1:0]       match_idx_reg, match_idx_next;
    logic [1:0]          match_kind_reg, match_kind_next;
    logic                adm_found_reg, adm_found_next;
    logic [IW-1:0]       adm_idx_reg, adm_idx_next;
    logic                free_found_reg, free_found_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;
    logic                tgt_found_reg, tgt_found_next;
    logic [IW-1:0]       tgt_idx_reg, tgt_idx_next;
    logic                nfree_found_reg, nfree_found_next;
    logic [IW-1:0]       nfree_idx_reg, nfree_idx_next;
    logic                status_reg, status_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_status_reg, m_status_next;
    logic [6:0]          m_slot_reg, m_slot_next;
    logic                m_free_found_reg, m_free_found_next;
    logic [6:0]          m_free_slot_reg, m_free_slot_next;
    logic                last_pos;
    logic                type_ok;
    entry_t              e;
    entry_t              w;

    assign e        = head_entry;
    assign last_pos = (pos_reg == IW'(TABLE_ENTRIES - 1));
    assign type_ok  = (type_reg == KIND_ADMIN) || (type_reg == KIND_USER);

    always_comb begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        type_next         = type_reg;
        idx_next          = idx_reg;
        match_found_next  = match_found_reg;
        match_idx_next    = match_idx_reg;
        match_kind_next   = match_kind_reg;
        adm_found_next    = adm_found_reg;
        adm_idx_next      = adm_idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        tgt_found_next    = tgt_found_reg;
        tgt_idx_next      = tgt_idx_reg;
        nfree_found_next  = nfree_found_reg;
        nfree_idx_next    = nfree_idx_reg;
        status_next       = status_reg;
        slot_next         = slot_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_slot_next       = m_slot_reg;
        m_free_found_next = m_free_found_reg;
        m_free_slot_next  = m_free_slot_reg;
        w                 = e;
        shift_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next          = op_t'(s_opcode);
                    key_next         = pack_key(s_digits, s_digit_count);
                    type_next        = s_code_type;
                    idx_next         = s_entry_index;
                    match_found_next = 1'b0;
                    adm_found_next   = 1'b0;
                    free_found_next  = 1'b0;
                    pos_next         = '0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                shift_en = 1'b1;
                if (!match_found_reg && e.valid && e.key == key_reg) begin
                    match_found_next = 1'b1;
                    match_idx_next   = pos_reg;
                    match_kind_next  = e.kind;
                end
                if (!adm_found_reg && e.valid && e.kind == KIND_ADMIN) begin
                    adm_found_next = 1'b1;
                    adm_idx_next   = pos_reg;
                end
                if (!free_found_reg && !e.valid) begin
                    free_found_next = 1'b1;
                    free_idx_next   = pos_reg;
                end
                pos_next = last_pos ? '0 : pos_reg + 1'b1;
                if (last_pos) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                status_next      = 1'b1;
                slot_next        = '0;
                tgt_found_next   = 1'b0;
                tgt_idx_next     = free_idx_reg;
                nfree_found_next = 1'b0;
                nfree_idx_next   = '0;
                unique case (op_reg)
                    OP_CHECK: begin
                        if (match_found_reg &&
                            (match_kind_reg == type_reg || type_reg == KIND_ANY)) begin
                            status_next = 1'b0;
                            slot_next   = match_idx_reg;
                        end
                    end
                    OP_STORE: begin
                        if (type_reg == KIND_ADMIN && adm_found_reg) begin
                            tgt_found_next = 1'b1;
                            tgt_idx_next   = adm_idx_reg;
                            status_next    = 1'b0;
                            slot_next      = adm_idx_reg;
                        end else if (type_ok && free_found_reg) begin
                            tgt_found_next = 1'b1;
                            status_next    = 1'b0;
                            slot_next      = free_idx_reg;
                        end
                    end
                    OP_DELETE: begin
                        status_next = 1'b1;
                    end
                    OP_CLEAR: begin
                        status_next = 1'b0;
                    end
                    default: begin
                        status_next = 1'b1;
                    end
                endcase
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                shift_en = 1'b1;
                unique case (op_reg)
                    OP_STORE: begin
                        if (tgt_found_reg && pos_reg == tgt_idx_reg) begin
                            w.valid = 1'b1;
                            w.key   = key_reg;
                            w.kind  = type_reg;
                        end
                    end
                    OP_DELETE: begin
                        if (type_ok && 9'(pos_reg) == 9'(idx_reg) && e.valid &&
                            e.kind == type_reg) begin
                            w.valid     = 1'b0;
                            status_next = 1'b0;
                        end
                    end
                    OP_CLEAR: begin
                        if (e.valid && e.kind == KIND_USER) begin
                            w.valid = 1'b0;
                        end
                    end
                    default: begin
                        w = e;
                    end
                endcase
                if (!nfree_found_reg && !w.valid) begin
                    nfree_found_next = 1'b1;
                    nfree_idx_next   = pos_reg;
                end
                pos_next = last_pos ? '0 : pos_reg + 1'b1;
                if (last_pos) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = status_reg;
                    m_slot_next       = 7'(slot_reg);
                    m_free_found_next = nfree_found_reg;
                    m_free_slot_next  = nfree_found_reg ? 7'(nfree_idx_reg) : 7'd0;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg          <= pos_next;
        op_reg           <= op_next;
        key_reg          <= key_next;
        type_reg         <= type_next;
        idx_reg          <= idx_next;
        match_found_reg  <= match_found_next;
        match_idx_reg    <= match_idx_next;
        match_kind_reg   <= match_kind_next;
        adm_found_reg    <= adm_found_next;
        adm_idx_reg      <= adm_idx_next;
        free_found_reg   <= free_found_next;
        free_idx_reg     <= free_idx_next;
        tgt_found_reg    <= tgt_found_next;
        tgt_idx_reg      <= tgt_idx_next;
        nfree_found_reg  <= nfree_found_next;
        nfree_idx_reg    <= nfree_idx_next;
        status_reg       <= status_next;
        slot_reg         <= slot_next;
        m_status_reg     <= m_status_next;
        m_slot_reg       <= m_slot_next;
        m_free_found_reg <= m_free_found_next;
        m_free_slot_reg  <= m_free_slot_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign wb_entry     = w;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot       = m_slot_reg;
    assign m_free_found = m_free_found_reg;
    assign m_free_slot  = m_free_slot_reg;

endmodule

// File: sv/credential_code_table.sv
// One item in flight: s_ready is high only while the controller is idle.
// Each item takes two full rotations of the cell ring past the head: one
// to search, one to write back and find the lowest free slot.
// Reset: synchronous, active low; clears every entry's valid bit at once.
module credential_code_table
    import crd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_digits,
    input  logic [3:0]  s_digit_count,
    input  logic [1:0]  s_code_type,
    input  logic [6:0]  s_entry_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [6:0]  m_slot,
    output logic        m_free_found,
    output logic [6:0]  m_free_slot
);

    entry_t cell_q [TABLE_ENTRIES];
    entry_t wb_entry;
    logic   shift_en;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        entry_t cell_d;
        if (g == TABLE_ENTRIES - 1) begin : g_tail
            assign cell_d = wb_entry;
        end else begin : g_mid
            assign cell_d = cell_q[g+1];
        end
        crd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (shift_en),
            .entry_in  (cell_d),
            .entry_out (cell_q[g])
        );
    end

    crd_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_digits      (s_digits),
        .s_digit_count (s_digit_count),
        .s_code_type   (s_code_type),
        .s_entry_index (s_entry_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot        (m_slot),
        .m_free_found  (m_free_found),
        .m_free_slot   (m_free_slot),
        .head_entry    (cell_q[0]),
        .wb_entry      (wb_entry),
        .shift_en      (shift_en)
    );

endmodule

// File: sv/crd_checker.sv
module crd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_opcode,
    input logic [31:0] s_digits,
    input logic [3:0]  s_digit_count,
    input logic [1:0]  s_code_type,
    input logic [6:0]  s_entry_index,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_status,
    input logic [6:0]  m_slot,
    input logic        m_free_found,
    input logic [6:0]  m_free_slot
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot) &&
            $stable(m_free_found) && $stable(m_free_slot))
        else $error("stalled item changed");

    a_fail_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_slot == 7'd0)
        else $error("slot nonzero on failure");

    a_no_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_free_found |-> m_free_slot == 7'd0)
        else $error("free slot nonzero with table full");

endmodule

bind credential_code_table crd_checker u_crd_checker (.*);
